// ===== rtl/mss_pkg.sv =====
package mss_pkg;

  localparam int DIGITS   = 4;
  localparam int DIM_BITS = 4;
  localparam int DIG_W    = $clog2(DIGITS);

  localparam logic [7:0] DOT_BIT    = 8'h80;
  localparam logic [7:0] FIRST_CODE = 8'd45;
  localparam logic [7:0] LAST_CODE  = 8'd122;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_DOT_SET = 3'd2,
    OP_DOT_CLR = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_ENABLE     = 3'd1,
    REG_BLINK      = 3'd2,
    REG_ACTIVE_LOW = 3'd3,
    REG_REFRESH    = 3'd4,
    REG_BLINK_SLOTS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] digit;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] digit_select;
    logic [7:0] segment_lines;
  } out_item_t;

  localparam logic [7:0] ASCII_TABLE [78] = '{
    8'h40, 8'h00, 8'h00,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h77, 8'h00, 8'h39, 8'h00, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h30, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h00, 8'h3F, 8'h73, 8'h00, 8'h00, 8'h6D,
    8'h00, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08,
    8'h00, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h00, 8'h00, 8'h00, 8'h74, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h54, 8'h5C, 8'h00, 8'h67, 8'h50, 8'h00, 8'h78, 8'h1C, 8'h00, 8'h00,
    8'h00, 8'h6E, 8'h00
  };

  function automatic logic [7:0] decode_char(input logic [7:0] code);
    logic [7:0] offset;
    offset = code - FIRST_CODE;
    if (code < FIRST_CODE || code > LAST_CODE) begin
      return 8'h00;
    end
    return ASCII_TABLE[offset[6:0]];
  endfunction

endpackage

// ===== rtl/multiplexed_seven_segment_scanner.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    in_item_t  (op, digit, char_code)
// out      output     out_valid/out_stall  out_item_t (digit_select, segment_lines)
// cfg      input      cfg_write            cfg_index, cfg_data
//
// Each item is done in the cycle it is accepted; one item per clock unless stalled.
// A tick ending a scan slot puts one result in the output register or the buffer.
// A two-entry output buffer absorbs one result while the output is stalled;
// in_stall rises only when both entries are full.
// Sync reset restores defaults (not out_data/skid_data); all digits go blank.
module multiplexed_seven_segment_scanner
  import mss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] brightness_levels;
  logic [3:0]  enable_mask;
  logic [3:0]  blink_mask;
  logic        active_low;
  logic [15:0] refresh_ticks;
  logic [15:0] blink_slots;

  logic [15:0]         tick_counter, tick_counter_next;
  logic [DIG_W-1:0]    scan_index, scan_index_next;
  logic [15:0]         slot_counter, slot_counter_next;
  logic [3:0]          blink_phase, blink_phase_next;
  logic [DIM_BITS-1:0] dim_counters [DIGITS];
  logic [DIM_BITS-1:0] dim_counters_next [DIGITS];
  logic [7:0]          digit_patterns [DIGITS];
  logic [7:0]          digit_patterns_next [DIGITS];

  logic        skid_valid;
  out_item_t   skid_data;
  logic        res_valid;
  out_item_t   res_data;

  logic             accept;
  logic [DIG_W-1:0] addr;
  logic [7:0]       pattern;
  logic             digit_ok;
  logic [15:0]      slot_inc;
  logic             visible;
  logic [7:0]       seg;
  logic [31:0]      level_word;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    tick_counter_next   = tick_counter;
    scan_index_next     = scan_index;
    slot_counter_next   = slot_counter;
    blink_phase_next    = blink_phase;
    dim_counters_next   = dim_counters;
    digit_patterns_next = digit_patterns;
    res_valid           = 1'b0;
    res_data            = '0;
    slot_inc            = slot_counter + 16'd1;
    visible             = 1'b0;
    seg                 = 8'h00;
    level_word          = 32'(brightness_levels) >> (DIM_BITS * 32'(scan_index));
    digit_ok            = 32'(in_data.digit) < DIGITS;
    addr                = (op_t'(in_data.op) == OP_TICK) ? scan_index
                                                         : in_data.digit[DIG_W-1:0];
    pattern             = digit_patterns[addr];

    if (accept) begin
      case (op_t'(in_data.op))
        OP_WRITE: begin
          if (digit_ok) begin
            digit_patterns_next[addr] = decode_char(in_data.char_code) | (pattern & DOT_BIT);
          end
        end
        OP_DOT_SET: begin
          if (digit_ok) begin
            digit_patterns_next[addr] = pattern | DOT_BIT;
          end
        end
        OP_DOT_CLR: begin
          if (digit_ok) begin
            digit_patterns_next[addr] = pattern & ~DOT_BIT;
          end
        end
        OP_CLEAR: begin
          if (digit_ok) begin
            digit_patterns_next[addr] = 8'h00;
          end
        end
        OP_TICK: begin
          if (tick_counter < refresh_ticks) begin
            tick_counter_next = tick_counter + 16'd1;
          end else begin
            tick_counter_next = 16'd0;
            if (slot_inc >= blink_slots) begin
              slot_counter_next = 16'd0;
              blink_phase_next  = blink_phase ^ blink_mask;
            end else begin
              slot_counter_next = slot_inc;
            end
            visible = enable_mask[scan_index] &&
                      (!blink_mask[scan_index] || blink_phase_next[scan_index]);
            if (dim_counters[scan_index] == '0) begin
              if (visible) begin
                seg = pattern;
                dim_counters_next[scan_index] = level_word[DIM_BITS-1:0];
              end
            end else begin
              dim_counters_next[scan_index] = dim_counters[scan_index] - 1'b1;
            end
            res_valid              = 1'b1;
            res_data.digit_select  = 2'(scan_index);
            res_data.segment_lines = seg ^ {8{active_low}};
            scan_index_next = (scan_index == DIG_W'(DIGITS - 1)) ? '0
                                                                 : scan_index + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_levels <= 16'd0;
      enable_mask       <= 4'hF;
      blink_mask        <= 4'h0;
      active_low        <= 1'b0;
      refresh_ticks     <= 16'd1;
      blink_slots       <= 16'd1000;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BRIGHTNESS:  brightness_levels <= cfg_data;
        REG_ENABLE:      enable_mask       <= cfg_data[3:0];
        REG_BLINK:       blink_mask        <= cfg_data[3:0];
        REG_ACTIVE_LOW:  active_low        <= cfg_data[0];
        REG_REFRESH:     refresh_ticks     <= cfg_data;
        REG_BLINK_SLOTS: blink_slots       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= 16'd0;
      scan_index   <= '0;
      slot_counter <= 16'd0;
      blink_phase  <= 4'hF;
      for (int i = 0; i < DIGITS; i++) begin
        dim_counters[i]   <= '1;
        digit_patterns[i] <= 8'h00;
      end
    end else begin
      tick_counter   <= tick_counter_next;
      scan_index     <= scan_index_next;
      slot_counter   <= slot_counter_next;
      blink_phase    <= blink_phase_next;
      dim_counters   <= dim_counters_next;
      digit_patterns <= digit_patterns_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (res_valid) begin
        out_data <= res_data;
      end
    end else if (res_valid) begin
      skid_data <= res_data;
    end
  end

  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("Input stalled while the output register is empty.");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> out_valid)
    else $error("Buffered result was lost.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(scan_index) < DIGITS)
    else $error("Scan index beyond the last digit.");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import mss_pkg::*;

  localparam int LIMIT = 200000;
  localparam int SETTLE = 4;
  localparam int LONG_HOLD = 60;
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [15:0] levels;
    logic [15:0] enables;
    logic [15:0] blinks;
    logic [15:0] polarity;
    logic [15:0] refresh;
    logic [15:0] blink_len;
    int          items;
  } setting_t;

  class scan_model;
    logic [15:0]         levels;
    logic [3:0]          en_mask;
    logic [3:0]          blink_mask;
    logic                inv;
    logic [15:0]         refresh;
    logic [15:0]         blink_len;
    logic [15:0]         tick_cnt;
    logic [15:0]         slot_cnt;
    logic [DIG_W-1:0]    scan_idx;
    logic [3:0]          phase;
    logic [DIM_BITS-1:0] dim [DIGITS];
    logic [7:0]          pattern [DIGITS];
    out_item_t           frames_due[$];
    int                  errors;

    function new();
      levels = '0;
      en_mask = 4'hF;
      blink_mask = '0;
      inv = 1'b0;
      refresh = 16'd1;
      blink_len = 16'd1000;
      tick_cnt = '0;
      slot_cnt = '0;
      scan_idx = '0;
      phase = 4'hF;
      errors = 0;
      foreach (dim[d]) begin
        dim[d] = '1;
        pattern[d] = '0;
      end
    endfunction

    function logic [7:0] glyph(logic [7:0] code);
      case (code)
        8'h2D: return 8'h40;
        8'h30: return 8'h3F;
        8'h31: return 8'h06;
        8'h32: return 8'h5B;
        8'h33: return 8'h4F;
        8'h34: return 8'h66;
        8'h35: return 8'h6D;
        8'h36: return 8'h7D;
        8'h37: return 8'h07;
        8'h38: return 8'h7F;
        8'h39: return 8'h6F;
        8'h41: return 8'h77;
        8'h43: return 8'h39;
        8'h45: return 8'h79;
        8'h46: return 8'h71;
        8'h47: return 8'h3D;
        8'h48: return 8'h76;
        8'h49: return 8'h30;
        8'h4A: return 8'h1E;
        8'h4C: return 8'h38;
        8'h4F: return 8'h3F;
        8'h50: return 8'h73;
        8'h53: return 8'h6D;
        8'h55: return 8'h3E;
        8'h5F: return 8'h08;
        8'h61: return 8'h5F;
        8'h62: return 8'h7C;
        8'h63: return 8'h58;
        8'h64: return 8'h5E;
        8'h68: return 8'h74;
        8'h6E: return 8'h54;
        8'h6F: return 8'h5C;
        8'h71: return 8'h67;
        8'h72: return 8'h50;
        8'h74: return 8'h78;
        8'h75: return 8'h1C;
        8'h79: return 8'h6E;
        default: return 8'h00;
      endcase
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_BRIGHTNESS:  levels = v;
        REG_ENABLE:      en_mask = v[3:0];
        REG_BLINK:       blink_mask = v[3:0];
        REG_ACTIVE_LOW:  inv = v[0];
        REG_REFRESH:     refresh = v;
        REG_BLINK_SLOTS: blink_len = v;
        default: ;
      endcase
    endfunction

    function void take_item(in_item_t it);
      logic [7:0] seg;
      int         d;
      case (it.op)
        OP_WRITE:   pattern[it.digit] = glyph(it.char_code) | (pattern[it.digit] & DOT_BIT);
        OP_DOT_SET: pattern[it.digit] = pattern[it.digit] | DOT_BIT;
        OP_DOT_CLR: pattern[it.digit] = pattern[it.digit] & ~DOT_BIT;
        OP_CLEAR:   pattern[it.digit] = '0;
        OP_TICK: begin
          if (tick_cnt < refresh) begin
            tick_cnt = tick_cnt + 16'd1;
          end else begin
            tick_cnt = '0;
            slot_cnt = slot_cnt + 16'd1;
            if (slot_cnt >= blink_len) begin
              slot_cnt = '0;
              phase = phase ^ blink_mask;
            end
            d = scan_idx;
            seg = '0;
            if (dim[d] == '0) begin
              if (en_mask[d] && (!blink_mask[d] || phase[d])) begin
                seg = pattern[d];
                dim[d] = levels[d*DIM_BITS +: DIM_BITS];
              end
            end else begin
              dim[d] = dim[d] - 1'b1;
            end
            if (inv) begin
              seg = ~seg;
            end
            frames_due.push_back('{digit_select: scan_idx, segment_lines: seg});
            scan_idx = (d == DIGITS - 1) ? '0 : scan_idx + 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_frame(out_item_t got);
      out_item_t want;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame, expected none, actual digit %0d segments %h",
                 $time, got.digit_select, got.segment_lines);
        return;
      end
      want = frames_due.pop_front();
      if (got.digit_select !== want.digit_select) begin
        errors++;
        $display("%0t: digit_select expected %0d actual %0d",
                 $time, want.digit_select, got.digit_select);
      end
      if (got.segment_lines !== want.segment_lines) begin
        errors++;
        $display("%0t: segment_lines expected %h actual %h",
                 $time, want.segment_lines, got.segment_lines);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  scan_model sb;
  int        send_quiet;
  int        recv_quiet;

  multiplexed_seven_segment_scanner u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Most transfers wait a randomly drawn gap first; now and then a run of back-to-back transfers.
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic in_item_t make_item(logic [2:0] op, logic [1:0] dg, logic [7:0] code);
    in_item_t it;
    it.op = op;
    it.digit = dg;
    it.char_code = code;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it.digit = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1) != 0) begin
      it.char_code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
    end else begin
      it.char_code = 8'($urandom_range(0, 255));
    end
    if (pick < 55) begin
      it.op = OP_TICK;
    end else if (pick < 75) begin
      it.op = OP_WRITE;
    end else if (pick < 85) begin
      it.op = OP_DOT_SET;
    end else if (pick < 92) begin
      it.op = OP_DOT_CLR;
    end else if (pick < 97) begin
      it.op = OP_CLEAR;
    end else begin
      it.op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(REG_BRIGHTNESS, s.levels);
    write_reg(REG_ENABLE, s.enables);
    write_reg(REG_BLINK, s.blinks);
    write_reg(REG_ACTIVE_LOW, s.polarity);
    write_reg(REG_REFRESH, s.refresh);
    write_reg(REG_BLINK_SLOTS, s.blink_len);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (sb.frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int gap;
    int taken;
    bit held;
    out_stall = 1'b0;
    taken = 0;
    held = 1'b0;
    recv_quiet = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap(recv_quiet);
      // One long hold-off lets the output buffer fill so the input side stalls.
      if (!held && taken == 20) begin
        gap = LONG_HOLD;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_frame(out_data);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    setting_t plan[$];
    setting_t s;
    in_item_t directed[$];

    sb = new();
    send_quiet = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;

    plan.push_back('{16'h0000, 16'h000F, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 250});
    plan.push_back('{16'hFFFF, 16'hFFF0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20});
    plan.push_back('{16'h0F30, 16'h000B, 16'h0005, 16'h0001, 16'h0002, 16'h0000, 200});
    repeat (3) begin
      s.levels = 16'($urandom);
      s.enables = 16'($urandom);
      s.blinks = 16'($urandom);
      s.polarity = 16'($urandom);
      s.refresh = 16'($urandom_range(0, 3));
      s.blink_len = 16'($urandom_range(0, 12));
      s.items = 150;
      plan.push_back(s);
    end
    plan.push_back('{16'h0000, 16'h000F, 16'h000F, 16'h0000, 16'h0001, 16'h0003, 100});

    directed.push_back(make_item(OP_WRITE, 2'd0, 8'h2D));
    directed.push_back(make_item(OP_WRITE, 2'd1, 8'h30));
    directed.push_back(make_item(OP_WRITE, 2'd2, 8'h39));
    directed.push_back(make_item(OP_WRITE, 2'd3, 8'h7A));
    directed.push_back(make_item(OP_TICK, 2'd3, 8'hFF));
    directed.push_back(make_item(OP_WRITE, 2'd0, 8'h2C));
    directed.push_back(make_item(OP_WRITE, 2'd1, 8'h7B));
    directed.push_back(make_item(OP_WRITE, 2'd2, 8'h00));
    directed.push_back(make_item(OP_WRITE, 2'd3, 8'hFF));
    directed.push_back(make_item(OP_TICK, 2'd0, 8'h00));
    directed.push_back(make_item(OP_WRITE, 2'd1, 8'h79));
    directed.push_back(make_item(OP_WRITE, 2'd2, 8'h41));
    directed.push_back(make_item(OP_DOT_SET, 2'd0, 8'h00));
    directed.push_back(make_item(OP_DOT_SET, 2'd3, 8'h00));
    directed.push_back(make_item(OP_DOT_CLR, 2'd3, 8'h00));
    directed.push_back(make_item(OP_DOT_SET, 2'd1, 8'h00));
    directed.push_back(make_item(OP_WRITE, 2'd0, 8'h38));
    directed.push_back(make_item(OP_CLEAR, 2'd1, 8'h00));
    directed.push_back(make_item(OP_RSVD_LO, 2'd2, 8'h35));
    directed.push_back(make_item(OP_RSVD_MID, 2'd1, 8'hAA));
    directed.push_back(make_item(OP_RSVD_HI, 2'd3, 8'h55));
    directed.push_back(make_item(OP_TICK, 2'd1, 8'h55));
    directed.push_back(make_item(OP_TICK, 2'd2, 8'hAA));
    directed.push_back(make_item(OP_TICK, 2'd3, 8'h00));
    directed.push_back(make_item(OP_TICK, 2'd0, 8'hFF));

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_item(directed[i]);
    end
    in_valid <= 1'b0;
    drain();

    foreach (plan[p]) begin
      if (p == 1) begin
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h5A5A);
      end
      apply_setting(plan[p]);
      repeat (plan[p].items) send_item(random_item());
      in_valid <= 1'b0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mss_pkg.sv
rtl/multiplexed_seven_segment_scanner.sv
tb/tb_top.sv
